### rtl/bole_pkg.sv
// ----------------------------------------------------------------------------
// bole_pkg
// shared widths, codes and types of the bounded ordered list engine
// ----------------------------------------------------------------------------
`default_nettype none

package bole_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);
  localparam int POS_W   = 7;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 7;
  localparam int CMP_W   = (POS_W > CNT_W) ? POS_W : CNT_W;

  localparam int GRP_SZ  = 8;
  localparam int NGRP    = (DEPTH + GRP_SZ - 1) / GRP_SZ;

  localparam int IN_FIELDS_W  = 3 + POS_W + DATA_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 + 1 + DATA_W + COUNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ACT_PUSH_BACK  = 3'd0,
    ACT_POP_BACK   = 3'd1,
    ACT_PUSH_FRONT = 3'd2,
    ACT_POP_FRONT  = 3'd3,
    ACT_INSERT_AT  = 3'd4,
    ACT_REMOVE_AT  = 3'd5,
    ACT_CONTAINS   = 3'd6,
    ACT_READ_AT    = 3'd7
  } action_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_EMPTY = 2'd1,
    STS_RANGE = 2'd2,
    STS_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_TREE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic              go;
    logic              ins;
    logic              rem;
    logic              rd;
    logic              look;
    logic [CMP_W-1:0]  pos;
    logic [CMP_W-1:0]  cnt;
    logic [DATA_W-1:0] value;
  } cell_cmd_t;

endpackage

`default_nettype wire

### rtl/bole_cell.sv
// ----------------------------------------------------------------------------
// bole_cell
// one list entry: shifts with its neighbors on insert and remove, taps its
// value for reads and compares it for membership tests
// ----------------------------------------------------------------------------
`default_nettype none

module bole_cell (
  input  wire                             clk,
  input  wire  [bole_pkg::IDX_W-1:0]      cell_idx,
  input  wire  bole_pkg::cell_cmd_t       cmd,
  input  wire  [bole_pkg::DATA_W-1:0]     prev_entry,
  input  wire  [bole_pkg::DATA_W-1:0]     next_entry,
  output logic [bole_pkg::DATA_W-1:0]     entry_r,
  output logic [bole_pkg::DATA_W-1:0]     tap_data_r,
  output logic                            tap_match_r
);
  import bole_pkg::*;

  logic [CMP_W-1:0]  idx;
  logic [DATA_W-1:0] entry_nxt;
  logic [DATA_W-1:0] tap_data_nxt;
  logic              tap_match_nxt;

  always_comb begin
    idx       = CMP_W'(cell_idx);
    entry_nxt = entry_r;
    if (cmd.ins) begin
      if (idx > cmd.pos) begin
        entry_nxt = prev_entry;
      end else if (idx == cmd.pos) begin
        entry_nxt = cmd.value;
      end
    end else if (cmd.rem) begin
      if (idx >= cmd.pos) begin
        entry_nxt = next_entry;
      end
    end
    tap_data_nxt  = (cmd.rd && idx == cmd.pos) ? entry_r : '0;
    tap_match_nxt = cmd.look && (idx < cmd.cnt) && (entry_r == cmd.value);
  end

  always_ff @(posedge clk) begin
    if (cmd.go) begin
      entry_r     <= entry_nxt;
      tap_data_r  <= tap_data_nxt;
      tap_match_r <= tap_match_nxt;
    end
  end

endmodule

`default_nettype wire

### rtl/bole_reduce.sv
// ----------------------------------------------------------------------------
// bole_reduce
// registered or-tree that collects the cell taps into read data and found
// ----------------------------------------------------------------------------
`default_nettype none

module bole_reduce (
  input  wire                         clk,
  input  wire                         load,
  input  wire  [bole_pkg::DATA_W-1:0] tap_data [bole_pkg::DEPTH],
  input  wire  [bole_pkg::DEPTH-1:0]  tap_match,
  output logic [bole_pkg::DATA_W-1:0] data,
  output logic                        found
);
  import bole_pkg::*;

  logic [DATA_W-1:0] grp_data_r  [NGRP];
  logic [DATA_W-1:0] grp_data_nxt[NGRP];
  logic [NGRP-1:0]   grp_match_r;
  logic [NGRP-1:0]   grp_match_nxt;

  always_comb begin
    for (int g = 0; g < NGRP; g++) begin
      grp_data_nxt[g]  = '0;
      grp_match_nxt[g] = 1'b0;
      for (int k = 0; k < GRP_SZ; k++) begin
        if (g * GRP_SZ + k < DEPTH) begin
          grp_data_nxt[g]  = grp_data_nxt[g] | tap_data[g * GRP_SZ + k];
          grp_match_nxt[g] = grp_match_nxt[g] | tap_match[g * GRP_SZ + k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_data_r  <= grp_data_nxt;
      grp_match_r <= grp_match_nxt;
    end
  end

  always_comb begin
    data = '0;
    for (int g = 0; g < NGRP; g++) begin
      data = data | grp_data_r[g];
    end
    found = |grp_match_r;
  end

endmodule

`default_nettype wire

### rtl/bole_ctrl.sv
// ----------------------------------------------------------------------------
// bole_ctrl
// request decode, status and count, and the handshake sequencer
// ----------------------------------------------------------------------------
`default_nettype none

module bole_ctrl (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          in_tvalid,
  input  wire  bole_pkg::action_t      action,
  input  wire  [bole_pkg::POS_W-1:0]   position,
  input  wire  [bole_pkg::DATA_W-1:0]  value,
  input  wire                          out_tready,
  output logic                         in_tready,
  output logic                         out_tvalid,
  output logic                         tree_load,
  output bole_pkg::cell_cmd_t          cmd,
  output bole_pkg::status_t            status_r,
  output logic [bole_pkg::COUNT_W-1:0] count_r
);
  import bole_pkg::*;

  state_t           state_r;
  state_t           state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  status_t          status_nxt;
  logic             accept;
  logic [CMP_W-1:0] cnt_ext;
  logic [CMP_W-1:0] pos_ext;
  logic [CMP_W-1:0] pos_eff;

  assign accept  = in_tvalid && in_tready;
  assign cnt_ext = CMP_W'(cnt_r);
  assign pos_ext = CMP_W'(position);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_tvalid) state_nxt = S_TREE;
      S_TREE:  state_nxt = S_OUT;
      S_OUT:   if (out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = (state_r == S_IDLE);
    tree_load  = (state_r == S_TREE);
    out_tvalid = (state_r == S_OUT);
  end

  always_comb begin
    status_nxt = STS_OK;
    cnt_nxt    = cnt_r;
    pos_eff    = pos_ext;
    cmd        = '0;
    cmd.value  = value;
    cmd.cnt    = cnt_ext;
    unique case (action)
      ACT_PUSH_BACK, ACT_PUSH_FRONT, ACT_INSERT_AT: begin
        if (action == ACT_PUSH_BACK) begin
          pos_eff = cnt_ext;
        end else if (action == ACT_PUSH_FRONT) begin
          pos_eff = '0;
        end
        if (pos_eff > cnt_ext) begin
          status_nxt = STS_RANGE;
        end else if (cnt_ext >= CMP_W'(DEPTH)) begin
          status_nxt = STS_FULL;
        end else begin
          cmd.ins = 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ACT_POP_BACK, ACT_POP_FRONT, ACT_REMOVE_AT: begin
        if (action == ACT_POP_BACK) begin
          pos_eff = cnt_ext - 1'b1;
        end else if (action == ACT_POP_FRONT) begin
          pos_eff = '0;
        end
        if (cnt_r == '0) begin
          status_nxt = STS_EMPTY;
        end else if (pos_eff >= cnt_ext) begin
          status_nxt = STS_RANGE;
        end else begin
          cmd.rem = 1'b1;
          cmd.rd  = 1'b1;
          cnt_nxt = cnt_r - 1'b1;
        end
      end
      ACT_CONTAINS: begin
        cmd.look = 1'b1;
      end
      ACT_READ_AT: begin
        if (cnt_r == '0) begin
          status_nxt = STS_EMPTY;
        end else if (pos_eff >= cnt_ext) begin
          status_nxt = STS_RANGE;
        end else begin
          cmd.rd = 1'b1;
        end
      end
      default: status_nxt = STS_OK;
    endcase
    cmd.pos = pos_eff;
    cmd.go  = accept;
    if (!accept) begin
      cmd.ins  = 1'b0;
      cmd.rem  = 1'b0;
      cmd.rd   = 1'b0;
      cmd.look = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
      count_r  <= COUNT_W'(cnt_nxt);
    end
  end

endmodule

`default_nettype wire

### rtl/bounded_ordered_list_engine.sv
// ----------------------------------------------------------------------------
// bounded_ordered_list_engine
// ordered list of signed words with push/pop at both ends, positional insert,
// remove, read and membership test, held in a shifting chain of cells
// ----------------------------------------------------------------------------
//   channel  | dir | tdata fields (low bit up)                | width
//   in_      | in  | action[2:0] position[9:3] value[41:10]   | 48
//   out_     | out | status[1:0] found[2] data[34:3] cnt[41:35]| 48
//
// a request passes from in beat to out beat through the cells, which shift and
// tap, and then the registered or-tree over the cells, then the result is
// offered; a new request is taken in the cycle after the result beat, so the
// engine takes no new request while one is in flight.
// reset clears the count and the sequencer; entries hold no reset value.
// a stalled result holds its beat and blocks the input side.
// ----------------------------------------------------------------------------
`default_nettype none

module bounded_ordered_list_engine (
  input  wire                               clk,
  input  wire                               rst_n,
  input  wire                               in_tvalid,
  output logic                              in_tready,
  input  wire  [bole_pkg::IN_TDATA_W-1:0]   in_tdata,   // action, position, value
  output logic                              out_tvalid,
  input  wire                               out_tready,
  output logic [bole_pkg::OUT_TDATA_W-1:0]  out_tdata   // status, found, data, count
);
  import bole_pkg::*;

  action_t            action;
  logic [POS_W-1:0]   position;
  logic [DATA_W-1:0]  value;
  cell_cmd_t          cmd;
  status_t            status_r;
  logic [COUNT_W-1:0] count_r;
  logic               tree_load;
  logic [DATA_W-1:0]  entry_q  [DEPTH];
  logic [DATA_W-1:0]  tap_data [DEPTH];
  logic [DEPTH-1:0]   tap_match;
  logic [DATA_W-1:0]  rd_data;
  logic               found;

  assign action   = action_t'(in_tdata[2:0]);
  assign position = in_tdata[3 +: POS_W];
  assign value    = in_tdata[3 + POS_W +: DATA_W];

  bole_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .action     (action),
    .position   (position),
    .value      (value),
    .out_tready (out_tready),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .tree_load  (tree_load),
    .cmd        (cmd),
    .status_r   (status_r),
    .count_r    (count_r)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bole_cell u_cell (
      .clk         (clk),
      .cell_idx    (IDX_W'(i)),
      .cmd         (cmd),
      .prev_entry  (entry_q[(i == 0) ? 0 : i - 1]),
      .next_entry  (entry_q[(i == DEPTH - 1) ? DEPTH - 1 : i + 1]),
      .entry_r     (entry_q[i]),
      .tap_data_r  (tap_data[i]),
      .tap_match_r (tap_match[i])
    );
  end

  bole_reduce u_reduce (
    .clk       (clk),
    .load      (tree_load),
    .tap_data  (tap_data),
    .tap_match (tap_match),
    .data      (rd_data),
    .found     (found)
  );

  assign out_tdata = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), count_r, rd_data, found, status_r};

endmodule

`default_nettype wire

### rtl/bole_chk.sv
// ----------------------------------------------------------------------------
// bole_chk
// port-level checks of the list engine, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module bole_chk (
  input wire                              clk,
  input wire                              rst_n,
  input wire                              in_tvalid,
  input wire                              in_tready,
  input wire                              out_tvalid,
  input wire                              out_tready,
  input wire [bole_pkg::OUT_TDATA_W-1:0]  out_tdata
);
  import bole_pkg::*;

  // one request in flight
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a request is in flight");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_back_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready |=> in_tready && !out_tvalid)
    else $error("engine not idle after result beat");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered right after reset");

  // found only on a successful lookup
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[2] |-> out_tdata[1:0] == STS_OK && out_tdata[34:3] == '0)
    else $error("found set with bad status or data");

endmodule

bind bounded_ordered_list_engine bole_chk u_bole_chk (.*);

`default_nettype wire
